>>> sv/mcd_pkg.sv
package mcd_pkg;

  // longest code in the symbol table
  localparam int CODE_MAX_LEN = 6;
  localparam int CODE_LEN_W   = 3;

  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_UNKNOWN = 8'h40;

  // one finished code word, handed from front to back
  typedef struct packed {
    logic                  gap;       // space with nothing pending
    logic                  line_end;
    logic                  bad;       // empty, too long or stray character seen
    logic [CODE_LEN_W-1:0] len;
    logic [CODE_MAX_LEN-1:0] bits;    // dash is 1, first mark in highest used bit
  } mcd_cmd_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       line_end;
  } mcd_result_t;

  function automatic logic [7:0] mcd_lookup(input logic [CODE_LEN_W-1:0] len,
                                            input logic [CODE_MAX_LEN-1:0] bits);
    logic [7:0] sym;
    sym = CHAR_UNKNOWN;
    case ({len, bits})
      {3'd2, 6'b000001}: sym = "A";
      {3'd4, 6'b001000}: sym = "B";
      {3'd4, 6'b001010}: sym = "C";
      {3'd3, 6'b000100}: sym = "D";
      {3'd1, 6'b000000}: sym = "E";
      {3'd4, 6'b000010}: sym = "F";
      {3'd3, 6'b000110}: sym = "G";
      {3'd4, 6'b000000}: sym = "H";
      {3'd2, 6'b000000}: sym = "I";
      {3'd4, 6'b000111}: sym = "J";
      {3'd3, 6'b000101}: sym = "K";
      {3'd4, 6'b000100}: sym = "L";
      {3'd2, 6'b000011}: sym = "M";
      {3'd2, 6'b000010}: sym = "N";
      {3'd3, 6'b000111}: sym = "O";
      {3'd4, 6'b000110}: sym = "P";
      {3'd4, 6'b001101}: sym = "Q";
      {3'd3, 6'b000010}: sym = "R";
      {3'd3, 6'b000000}: sym = "S";
      {3'd1, 6'b000001}: sym = "T";
      {3'd3, 6'b000001}: sym = "U";
      {3'd4, 6'b000001}: sym = "V";
      {3'd3, 6'b000011}: sym = "W";
      {3'd4, 6'b001001}: sym = "X";
      {3'd4, 6'b001011}: sym = "Y";
      {3'd4, 6'b001100}: sym = "Z";
      {3'd5, 6'b011111}: sym = "0";
      {3'd5, 6'b001111}: sym = "1";
      {3'd5, 6'b000111}: sym = "2";
      {3'd5, 6'b000011}: sym = "3";
      {3'd5, 6'b000001}: sym = "4";
      {3'd5, 6'b000000}: sym = "5";
      {3'd5, 6'b010000}: sym = "6";
      {3'd5, 6'b011000}: sym = "7";
      {3'd5, 6'b011100}: sym = "8";
      {3'd5, 6'b011110}: sym = "9";
      {3'd6, 6'b010101}: sym = ".";
      {3'd6, 6'b110011}: sym = ",";
      {3'd6, 6'b001100}: sym = "?";
      {3'd6, 6'b011110}: sym = 8'h27;
      {3'd6, 6'b101011}: sym = "!";
      {3'd5, 6'b010010}: sym = "/";
      {3'd5, 6'b010110}: sym = "(";
      {3'd6, 6'b101101}: sym = ")";
      {3'd5, 6'b001000}: sym = "&";
      {3'd6, 6'b111000}: sym = ":";
      {3'd6, 6'b101010}: sym = ";";
      {3'd5, 6'b010001}: sym = "=";
      {3'd5, 6'b001010}: sym = "+";
      {3'd6, 6'b100001}: sym = "-";
      {3'd6, 6'b001101}: sym = "_";
      {3'd6, 6'b010010}: sym = 8'h22;
      {3'd6, 6'b011010}: sym = "@";
      default:           sym = CHAR_UNKNOWN;
    endcase
    return sym;
  endfunction

endpackage

>>> sv/mcd_fifo.sv
module mcd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> sv/mcd_front.sv
module mcd_front import mcd_pkg::*; #(
  parameter int MAX_MARKS = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] char_in,
  output logic       full,
  output logic       cmd_push,
  output mcd_cmd_t   cmd,
  input  logic       cmd_full
);

  localparam int CW = $clog2(MAX_MARKS + 1);

  logic [MAX_MARKS-1:0] pattern_r, pattern_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 invalid_r, invalid_nxt;
  logic                 accept, is_mark, is_term, is_space;

  assign full     = cmd_full;
  assign accept   = push & ~cmd_full;
  assign is_mark  = (char_in == CHAR_DOT) || (char_in == CHAR_DASH);
  assign is_space = (char_in == CHAR_SPACE);
  assign is_term  = is_space || (char_in == CHAR_NEWLINE);
  assign cmd_push = accept & is_term;

  always_comb begin
    cmd.gap      = is_space && (count_r == '0) && !invalid_r;
    cmd.line_end = !is_space;
    // codes longer than the table's longest can never match
    cmd.bad      = invalid_r || (count_r == '0) || (count_r > CW'(CODE_MAX_LEN));
    cmd.len      = count_r[CODE_LEN_W-1:0];
    cmd.bits     = pattern_r[CODE_MAX_LEN-1:0];
  end

  always_comb begin
    pattern_nxt = pattern_r;
    count_nxt   = count_r;
    invalid_nxt = invalid_r;
    if (accept) begin
      if (is_mark) begin
        if (count_r < CW'(MAX_MARKS)) begin
          pattern_nxt = {pattern_r[MAX_MARKS-2:0], char_in == CHAR_DASH};
          count_nxt   = count_r + CW'(1);
        end else begin
          invalid_nxt = 1'b1;
        end
      end else if (is_term) begin
        pattern_nxt = '0;
        count_nxt   = '0;
        invalid_nxt = 1'b0;
      end else begin
        invalid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      count_r   <= '0;
      invalid_r <= 1'b0;
    end else begin
      pattern_r <= pattern_nxt;
      count_r   <= count_nxt;
      invalid_r <= invalid_nxt;
    end
  end

endmodule

>>> sv/mcd_back.sv
module mcd_back import mcd_pkg::*; #(
  parameter int OUT_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mcd_cmd_t   cmd,
  input  logic       cmd_empty,
  output logic       cmd_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] symbol_out,
  output logic       line_end
);

  mcd_result_t res, res_q;
  logic        res_full;

  assign cmd_pop = ~cmd_empty & ~res_full;

  always_comb begin
    res.line_end = cmd.line_end;
    if (cmd.gap) begin
      res.symbol = CHAR_SPACE;
    end else if (cmd.bad) begin
      res.symbol = CHAR_UNKNOWN;
    end else begin
      res.symbol = mcd_lookup(cmd.len, cmd.bits);
    end
  end

  mcd_fifo #(
    .WIDTH ($bits(mcd_result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_pop),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_q),
    .empty (empty)
  );

  assign symbol_out = res_q.symbol;
  assign line_end   = res_q.line_end;

endmodule

>>> sv/morse_code_decoder_top.sv
// morse code decoder: text characters in, decoded ascii symbols out
//
// input side is a queue: drive in_char_in and push; a transfer happens on a
// clock edge with push high and full low. '.' and '-' build the code word,
// space or newline ends it, any other character poisons the code ('@').
// result side is a queue: out_symbol_out / out_line_end are valid while
// empty is low; a transfer happens on an edge with pop high and empty low.
// marks and stray characters give no result; each space or newline gives one.
//
// the command queue registers a code word when its terminating character
// is taken; the back stage then looks it up and writes the result into
// the result queue, whose head drives the out ports.
// throughput: one character per cycle while full is low, set by the
// combinational front classifier and table match in the back stage.
//
// stall: a held-off pop fills the result queue, then the command queue,
// and full rises; up to CMD_DEPTH + OUT_DEPTH results wait inside.
// reset (rst_n low, synchronous) drops any pending code and empties both
// queues; the first transfer can be taken as soon as rst_n is high again.
module morse_code_decoder_top import mcd_pkg::*; #(
  parameter int MAX_MARKS = 7,
  parameter int CMD_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] in_char_in,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_symbol_out,
  output logic       out_line_end
);

  mcd_cmd_t cmd_in, cmd_out;
  logic     cmd_push, cmd_full, cmd_pop, cmd_empty;

  mcd_front #(
    .MAX_MARKS (MAX_MARKS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .char_in  (in_char_in),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  mcd_fifo #(
    .WIDTH ($bits(mcd_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  mcd_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd_out),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .empty      (empty),
    .pop        (pop),
    .symbol_out (out_symbol_out),
    .line_end   (out_line_end)
  );

endmodule
